>>> rtl/core/slpl_pkg.sv
// ----------------------------------------------------------------------------
// slpl_pkg: shared constants and helpers for the stereo look-ahead limiter
// Widths, fixed point scales, register indexes and sample helpers.
// ----------------------------------------------------------------------------
package slpl_pkg;

  // Look-ahead ring
  localparam int LOOKAHEAD_DEPTH = 64;
  localparam int ADDR_W          = $clog2(LOOKAHEAD_DEPTH);
  localparam int CNT_W           = ADDR_W + 1;

  // Sample and gain formats
  localparam int SAMPLE_W = 24;                  // signed Q8.16
  localparam int MAG_W    = 23;                  // magnitude after clamp, up to 2^22
  localparam int OUT_W    = 18;                  // signed Q2.16 result
  localparam int CEIL_W   = 17;                  // unsigned Q1.16 ceiling
  localparam int COEF_W   = 24;                  // unsigned Q0.24 release
  localparam int GAIN_W   = 25;                  // unsigned Q1.24, up to 1.0
  localparam int FRAC_W   = 24;                  // gain fraction bits
  localparam int PROD_W   = 2 * GAIN_W;
  localparam int DIV_STEPS = FRAC_W;             // quotient bits
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Config port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_GAIN        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFFICIENT = 1'd1;

  // Reset values
  localparam logic [GAIN_W-1:0] UNITY_GAIN      = GAIN_W'(1) << FRAC_W;
  localparam logic [CEIL_W-1:0] CEILING_RESET   = CEIL_W'(58409);
  localparam logic [COEF_W-1:0] RELEASE_RESET   = COEF_W'(16771781);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_LIMIT = SAMPLE_W'(4194304);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [MAG_W-1:0]           mag_t;

  // Saturate an input sample to plus or minus 64.0
  function automatic sample_t clamp_sample(input sample_t v);
    sample_t r;
    r = v;
    if (v > SAMPLE_LIMIT) r = SAMPLE_LIMIT;
    if (v < -SAMPLE_LIMIT) r = -SAMPLE_LIMIT;
    return r;
  endfunction

  // Magnitude of a clamped sample
  function automatic mag_t sample_mag(input sample_t v);
    sample_t a;
    a = (v < 0) ? -v : v;
    return a[MAG_W-1:0];
  endfunction

endpackage

>>> rtl/core/stereo_lookahead_peak_limiter_unit.sv
// ----------------------------------------------------------------------------
// stereo_lookahead_peak_limiter_unit: linked stereo look-ahead peak limiter
// Delay rings, peak scan, gain divide, release filter and output gain.
// ----------------------------------------------------------------------------
// One stereo frame is taken per request; its result is the frame written
// LOOKAHEAD_DEPTH - 1 frames earlier, scaled by the limiter gain and held to
// plus or minus the ceiling. The peak scan reads both delay rings through one
// read port, one entry a cycle; when the window peak is above the ceiling, the
// gain divide retires one quotient bit a cycle, and one shared multiplier
// serves the release step and both output channels. The input is not ready
// during that work; a finished result waits in the output register and the
// next frame can be taken meanwhile. The rings read as zero after reset
// through per-entry valid bits, so no clearing pass is needed.
module stereo_lookahead_peak_limiter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [slpl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [slpl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [slpl_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [slpl_pkg::SAMPLE_W-1:0] right_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [slpl_pkg::OUT_W-1:0]    left_out,
  output logic signed [slpl_pkg::OUT_W-1:0]    right_out
);
  import slpl_pkg::*;

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_GAIN  = 3'd4;
  localparam logic [2:0] S_REL   = 3'd5;
  localparam logic [2:0] S_MULL  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state;
  logic       mul_r_done;                 // set after the first S_FIN cycle; right product ready

  // Config registers
  logic [CEIL_W-1:0] ceiling_gain;
  logic [COEF_W-1:0] release_coefficient;

  // Ring storage
  sample_t left_mem  [LOOKAHEAD_DEPTH];
  sample_t right_mem [LOOKAHEAD_DEPTH];
  logic [LOOKAHEAD_DEPTH-1:0] ent_valid;
  sample_t left_q, right_q;
  logic    q_valid;

  logic [ADDR_W-1:0] write_pointer;
  logic [ADDR_W-1:0] read_pointer;
  logic [CNT_W-1:0]  scan_cnt;
  logic              data_vld;
  logic [ADDR_W-1:0] data_addr;

  // Working registers
  mag_t              peak;
  sample_t           old_l, old_r;
  logic [MAG_W-1:0]  rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [GAIN_W-1:0] target;
  logic [GAIN_W-1:0] limiter_gain;
  logic [PROD_W-1:0] prod;
  logic signed [OUT_W-1:0] res_l;

  // Derived values
  logic              accept;
  sample_t           cl_l, cl_r, rd_l, rd_r;
  mag_t              mag_l, mag_r, mag_max;
  logic [MAG_W:0]    rem_sh;
  logic [GAIN_W-1:0] mul_a, mul_b;
  logic [GAIN_W-1:0] rel_gain;
  logic [FRAC_W-1:0] rel_step;
  logic signed [OUT_W-1:0] scaled;
  logic              out_free;
  logic              out_load;
  logic [ADDR_W-1:0] wp_inc;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == S_FIN) && mul_r_done && out_free;
  assign cl_l     = clamp_sample(left_in);
  assign cl_r     = clamp_sample(right_in);
  assign wp_inc   = (write_pointer == ADDR_W'(LOOKAHEAD_DEPTH - 1)) ? '0
                                                                    : write_pointer + 1'b1;

  // Scan data, never-written entries read as zero
  assign rd_l    = q_valid ? left_q  : '0;
  assign rd_r    = q_valid ? right_q : '0;
  assign mag_l   = sample_mag(rd_l);
  assign mag_r   = sample_mag(rd_r);
  assign mag_max = (mag_l > mag_r) ? mag_l : mag_r;

  // Restoring divide step
  assign rem_sh = {rem, 1'b0};

  // Release step from the shared product
  assign rel_step = prod[2*FRAC_W-1:FRAC_W];
  always_comb begin
    rel_gain = target - GAIN_W'(rel_step);
    if (rel_gain > UNITY_GAIN) rel_gain = UNITY_GAIN;
  end

  // Shared multiplier operand select
  always_comb begin
    case (state)
      S_GAIN: begin
        mul_a = GAIN_W'(release_coefficient);
        mul_b = target - limiter_gain;
      end
      S_MULL: begin
        mul_a = GAIN_W'(sample_mag(old_l));
        mul_b = limiter_gain;
      end
      default: begin
        mul_a = GAIN_W'(sample_mag(old_r));
        mul_b = limiter_gain;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Scale, clamp to ceiling and restore sign
  always_comb begin
    logic [MAG_W-1:0]  m;
    logic [CEIL_W-1:0] c;
    logic              neg;
    m = prod[FRAC_W+MAG_W-1:FRAC_W];
    c = (m > MAG_W'(ceiling_gain)) ? ceiling_gain : m[CEIL_W-1:0];
    neg = (state == S_FIN && mul_r_done) ? old_r[SAMPLE_W-1] : old_l[SAMPLE_W-1];
    scaled = neg ? -$signed(OUT_W'(c)) : $signed(OUT_W'(c));
  end

  // Ring memories, one write and one registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      left_mem[write_pointer]  <= cl_l;
      right_mem[write_pointer] <= cl_r;
    end
    left_q  <= left_mem[scan_cnt[ADDR_W-1:0]];
    right_q <= right_mem[scan_cnt[ADDR_W-1:0]];
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling_gain        <= CEILING_RESET;
      release_coefficient <= RELEASE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CEILING_GAIN:        ceiling_gain        <= cfg_data[CEIL_W-1:0];
        REG_RELEASE_COEFFICIENT: release_coefficient <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    q_valid   <= ent_valid[scan_cnt[ADDR_W-1:0]];
    data_addr <= scan_cnt[ADDR_W-1:0];
    if (state == S_SCAN && data_vld && data_addr == read_pointer) begin
      old_l <= rd_l;
      old_r <= rd_r;
    end
    // Left product is ready in the first S_FIN cycle
    if (state == S_FIN && !mul_r_done) res_l <= scaled;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mul_r_done    <= 1'b0;
      ent_valid     <= '0;
      write_pointer <= '0;
      read_pointer  <= '0;
      scan_cnt      <= '0;
      data_vld      <= 1'b0;
      peak          <= '0;
      rem           <= '0;
      div_cnt       <= '0;
      target        <= UNITY_GAIN;
      limiter_gain  <= UNITY_GAIN;
      out_valid     <= 1'b0;
      left_out      <= '0;
      right_out     <= '0;
    end else begin
      // Result register handshake
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            ent_valid[write_pointer] <= 1'b1;
            read_pointer <= wp_inc;
            scan_cnt     <= '0;
            data_vld     <= 1'b0;
            peak         <= '0;
            state        <= S_SCAN;
          end
        end
        // One entry a cycle, compare follows the registered read
        S_SCAN: begin
          data_vld <= (scan_cnt < CNT_W'(LOOKAHEAD_DEPTH));
          if (scan_cnt < CNT_W'(LOOKAHEAD_DEPTH)) scan_cnt <= scan_cnt + 1'b1;
          if (data_vld && mag_max > peak) peak <= mag_max;
          if (scan_cnt == CNT_W'(LOOKAHEAD_DEPTH)) state <= S_CHECK;
        end
        S_CHECK: begin
          data_vld <= 1'b0;
          scan_cnt <= '0;
          if (peak > MAG_W'(ceiling_gain)) begin
            rem     <= MAG_W'(ceiling_gain);
            target  <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end else begin
            target <= UNITY_GAIN;
            state  <= S_GAIN;
          end
        end
        // One quotient bit a cycle
        S_DIV: begin
          if (rem_sh >= {1'b0, peak}) begin
            rem    <= MAG_W'(rem_sh - {1'b0, peak});
            target <= {target[GAIN_W-2:0], 1'b1};
          end else begin
            rem    <= rem_sh[MAG_W-1:0];
            target <= {target[GAIN_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state <= S_GAIN;
        end
        // Attack at once, otherwise release through the multiplier
        S_GAIN: begin
          if (target < limiter_gain) begin
            limiter_gain <= target;
            state        <= S_MULL;
          end else begin
            state <= S_REL;
          end
        end
        S_REL: begin
          limiter_gain <= rel_gain;
          state        <= S_MULL;
        end
        S_MULL: begin
          mul_r_done <= 1'b0;
          state      <= S_FIN;
        end
        // First cycle launches the right product, then store when free
        S_FIN: begin
          mul_r_done <= 1'b1;
          if (out_load) begin
            left_out      <= res_l;
            right_out     <= scaled;
            write_pointer <= read_pointer;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/sv/stereo_lookahead_peak_limiter_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_lookahead_peak_limiter_unit_test: self-checking bench for the limiter
// Stereo frame requests are driven on the input handshake and every limited
// frame is checked against a bit-exact model of the delay rings, window peak,
// gain divide, release filter and output clamp. Directed corners come first,
// then randomized program passages under several register settings, with
// random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module stereo_lookahead_peak_limiter_unit_test;
  import slpl_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    logic signed [OUT_W-1:0] left_val;
    logic signed [OUT_W-1:0] right_val;
  } limited_frame_t;

  // DUT ports
  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  left_in = '0;
  logic signed [SAMPLE_W-1:0]  right_in = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [OUT_W-1:0]     left_out;
  logic signed [OUT_W-1:0]     right_out;

  // Limiter model state
  int               left_ring[LOOKAHEAD_DEPTH];
  int               right_ring[LOOKAHEAD_DEPTH];
  int               ring_wr;
  logic [GAIN_W-1:0] gain_q24;
  logic [CEIL_W-1:0] ceiling_q16;
  logic [COEF_W-1:0] release_q24;

  // Frames predicted but not yet seen on the output
  limited_frame_t pending_frames[$];

  // Run bookkeeping
  int error_count = 0;
  int frames_sent = 0;
  int frames_checked = 0;
  int register_writes = 0;
  bit idle_gaps_on = 1'b1;
  int hold_request = 0;

  stereo_lookahead_peak_limiter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .left_in   (left_in),
    .right_in  (right_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model of the limiter
  // ---------------------------------------------------------------------------

  // Saturate to +/-64.0
  function automatic int saturate_input(input logic signed [SAMPLE_W-1:0] s);
    int v;
    v = int'(s);
    if (v > 4194304) v = 4194304;
    if (v < -4194304) v = -4194304;
    return v;
  endfunction

  function automatic u64_t mag_of(input int v);
    if (v < 0) return u64_t'(-v);
    return u64_t'(v);
  endfunction

  // Gain, truncate toward zero, hold within +/-ceiling
  function automatic logic signed [OUT_W-1:0] scale_to_ceiling(input int s);
    u64_t       m;
    logic [63:0] r;
    m = (mag_of(s) * u64_t'(gain_q24)) >> FRAC_W;
    if (m > u64_t'(ceiling_q16)) m = u64_t'(ceiling_q16);
    r = (s < 0) ? (64'd0 - m) : m;
    return r[OUT_W-1:0];
  endfunction

  function automatic limited_frame_t predict_limited_frame(
    input logic signed [SAMPLE_W-1:0] l_raw,
    input logic signed [SAMPLE_W-1:0] r_raw
  );
    limited_frame_t res;
    u64_t           peak;
    u64_t           target;
    u64_t           recovery;
    u64_t           g;
    int             oldest;
    left_ring[ring_wr] = saturate_input(l_raw);
    right_ring[ring_wr] = saturate_input(r_raw);
    oldest = (ring_wr + 1) % LOOKAHEAD_DEPTH;

    // window peak over both rings
    peak = '0;
    for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
      if (mag_of(left_ring[i]) > peak) peak = mag_of(left_ring[i]);
      if (mag_of(right_ring[i]) > peak) peak = mag_of(right_ring[i]);
    end

    // target gain, truncated quotient
    if (peak > u64_t'(ceiling_q16)) target = (u64_t'(ceiling_q16) << FRAC_W) / peak;
    else target = u64_t'(UNITY_GAIN);

    // instant attack, one-pole release
    if (target < u64_t'(gain_q24)) begin
      g = target;
    end else begin
      recovery = (u64_t'(release_q24) * (target - u64_t'(gain_q24))) >> FRAC_W;
      g = target - recovery;
    end
    if (g > u64_t'(UNITY_GAIN)) g = u64_t'(UNITY_GAIN);
    gain_q24 = g[GAIN_W-1:0];

    res.left_val = scale_to_ceiling(left_ring[oldest]);
    res.right_val = scale_to_ceiling(right_ring[oldest]);
    ring_wr = oldest;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!idle_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Sample within +/-level, with occasional full-range and clamp corners
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int level);
    int v;
    case ($urandom_range(0, 19))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 6))
          0: v = 8388607;
          1: v = -8388608;
          2: v = 4194304;
          3: v = -4194304;
          4: v = 4194305;
          5: v = -4194305;
          default: v = 0;
        endcase
      end
      default: v = $urandom_range(0, 2 * level) - level;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_CEILING_GAIN) ceiling_q16 = data[CEIL_W-1:0];
    else if (idx == REG_RELEASE_COEFFICIENT) release_q24 = data[COEF_W-1:0];
    register_writes++;
  endtask

  // One frame request; valid stays up into the next request when no gap
  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    left_in = l;
    right_in = r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_frames.push_back(predict_limited_frame(l, r));
    frames_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      left_in = SAMPLE_W'($urandom);
      right_in = SAMPLE_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop sending and let every predicted frame come out
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, long hold on request, field checks
  // ---------------------------------------------------------------------------
  task automatic check_limited_frame();
    limited_frame_t want;
    if (pending_frames.size() == 0) begin
      $display("%0t: result with nothing pending, left_out %0d right_out %0d",
               $realtime, left_out, right_out);
      error_count++;
    end else begin
      want = pending_frames.pop_front();
      frames_checked++;
      if (left_out !== want.left_val) begin
        $display("%0t: left_out expected %0d actual %0d",
                 $realtime, want.left_val, left_out);
        error_count++;
      end
      if (right_out !== want.right_val) begin
        $display("%0t: right_out expected %0d actual %0d",
                 $realtime, want.right_val, right_out);
        error_count++;
      end
    end
  endtask

  initial begin
    int hold_left;
    int stall_left;
    int n;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst == 1'b0 && out_valid === 1'b1 && out_ready) check_limited_frame();
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ready = 1'b0;
          stall_left = n - 1;
        end else begin
          out_ready = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero window after reset: peak zero, unity target
  task automatic test_silent_window();
    idle_gaps_on = 1'b0;
    repeat (4) send_frame('0, '0);
  endtask

  // Field extremes and both sides of the +/-64.0 clamp, back to back
  task automatic test_input_clamp();
    send_frame(24'sh7FFFFF, 24'sh800000);
    send_frame(24'sh800000, 24'sh7FFFFF);
    send_frame(24'sd4194304, -24'sd4194304);
    send_frame(24'sd4194305, -24'sd4194305);
    send_frame(-24'sd1, 24'sd1);
    send_frame(24'sd58409, -24'sd58410);
    send_frame(24'sd65536, 24'sd0);
    send_frame(24'sh555555, 24'shAAAAAA);
    send_frame(24'shAAAAAA, 24'sh555555);
    send_frame('0, '0);
    idle_gaps_on = 1'b1;
  endtask

  // Zero ceiling, ceiling above 1.0, range ends, release ends
  task automatic test_register_corners();
    wait_for_drain();
    // upper data bits beyond the 17-bit ceiling are ignored
    write_register(REG_CEILING_GAIN, 24'hFE0000);
    repeat (3) send_frame(pick_sample(4194304), pick_sample(4194304));
    wait_for_drain();
    write_register(REG_CEILING_GAIN, 24'h01FFFF);
    repeat (3) send_frame(pick_sample(200000), pick_sample(200000));
    wait_for_drain();
    write_register(REG_CEILING_GAIN, 24'd4135);
    write_register(REG_RELEASE_COEFFICIENT, 24'd0);
    repeat (3) send_frame(pick_sample(100000), pick_sample(1000));
    wait_for_drain();
    write_register(REG_CEILING_GAIN, 24'd65536);
    write_register(REG_RELEASE_COEFFICIENT, 24'hFFFFFF);
    repeat (3) send_frame(pick_sample(1000), pick_sample(8388607));
  endtask

  // Program-like passages: quiet, moderate, loud and overload stretches
  task automatic test_random_program(input int phases, input int frames_per_phase);
    int passage_left;
    int level;
    logic [CFG_DATA_W-1:0] ceil_word;
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    passage_left = 0;
    level = 0;
    for (int p = 0; p < phases; p++) begin
      wait_for_drain();
      case ($urandom_range(0, 9))
        0: ceil_word = 24'd4135;
        1: ceil_word = 24'd65536;
        2: ceil_word = 24'd0;
        3: ceil_word = 24'h01FFFF;
        default: ceil_word = CFG_DATA_W'($urandom_range(4135, 65536));
      endcase
      ceil_word[CFG_DATA_W-1:CEIL_W] = (CFG_DATA_W - CEIL_W)'($urandom);
      write_register(REG_CEILING_GAIN, ceil_word);
      case ($urandom_range(0, 7))
        0: write_register(REG_RELEASE_COEFFICIENT, 24'd0);
        1: write_register(REG_RELEASE_COEFFICIENT, 24'hFFFFFF);
        2, 3: write_register(REG_RELEASE_COEFFICIENT, CFG_DATA_W'($urandom));
        default: write_register(REG_RELEASE_COEFFICIENT,
                                CFG_DATA_W'($urandom_range(16600000, 16777215)));
      endcase
      idle_gaps_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < frames_per_phase; k++) begin
        if (passage_left == 0) begin
          passage_left = $urandom_range(4, 40);
          case ($urandom_range(0, 3))
            0: level = $urandom_range(0, 40000);
            1: level = $urandom_range(40000, 200000);
            2: level = $urandom_range(200000, 4194304);
            default: level = 8388607;
          endcase
        end
        passage_left--;
        l = pick_sample(level);
        r = ($urandom_range(0, 7) == 0) ? '0 : pick_sample(level);
        send_frame(l, r);
      end
    end
    idle_gaps_on = 1'b1;
  endtask

  // Long output stall while requests keep coming, then drain fully
  task automatic test_output_backpressure();
    idle_gaps_on = 1'b0;
    @(posedge clk);
    hold_request = 2500;
    repeat (24) send_frame(pick_sample(300000), pick_sample(300000));
    idle_gaps_on = 1'b1;
    wait_for_drain();
    repeat (8) send_frame(pick_sample(50000), pick_sample(50000));
  endtask

  // Run limit
  initial begin
    #10_000_000;
    $display("stereo_lookahead_peak_limiter_unit: mismatch");
    $finish;
  end

  // Main sequence
  initial begin
    ring_wr = 0;
    gain_q24 = UNITY_GAIN;
    ceiling_q16 = CEILING_RESET;
    release_q24 = RELEASE_RESET;
    for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
      left_ring[i] = 0;
      right_ring[i] = 0;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_silent_window();
    test_input_clamp();
    test_register_corners();
    test_random_program(6, 65);
    test_output_backpressure();

    wait_for_drain();
    repeat (200) @(posedge clk);
    if (pending_frames.size() != 0) begin
      $display("%0t: %0d predicted frames never came out", $realtime, pending_frames.size());
      error_count++;
    end

    $display("%0d frame requests, %0d limited frames checked, %0d register writes",
             frames_sent, frames_checked, register_writes);
    $display("covered silent window, input clamp, zero and above-unity ceiling, release ends, long stall");
    if (error_count == 0) begin
      $display("stereo_lookahead_peak_limiter_unit: match");
    end else begin
      $display("stereo_lookahead_peak_limiter_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/slpl_pkg.sv
rtl/core/stereo_lookahead_peak_limiter_unit.sv
tb/sv/stereo_lookahead_peak_limiter_unit_test.sv
